// ===== hw/rtl/tsrm_pkg.sv =====
// package for the three-wire serial register master
// item types, opcodes, tick schedule constants and bcd helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsrm_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  localparam logic [5:0] PHASE_IDLE  = 6'd0;
  localparam logic [5:0] PHASE_FIRST = 6'd1;
  localparam logic [5:0] PHASE_READ  = 6'd17;
  localparam logic [5:0] PHASE_END   = 6'd33;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] command_byte;
    logic [7:0] write_value;
    logic       data_pin_level;
  } in_item_t;

  typedef struct packed {
    logic       enable_pin;
    logic       clock_pin;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic clk;
    logic dat;
    logic drv;
  } pins_t;

  // divide by ten through reciprocal 205 / 2048, exact for 8-bit values
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [18:0] prod;
    logic [4:0]  quo;
    logic [7:0]  rem;
    logic [8:0]  sum;
    prod = 19'(v) * 19'd205;
    quo  = prod[15:11];
    rem  = v - 8'(quo) * 8'd10;
    sum  = {quo, 4'b0000} + 9'(rem);
    return sum[7:0];
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    logic [7:0] hi;
    hi = 8'(v[7:4]) * 8'd10;
    return hi + 8'(v[3:0]);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsrm_core.sv =====
// transaction state and one-item step of the serial master
// depends on tsrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsrm_core import tsrm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire logic      bcd_i,
  input  wire in_item_t  item_i,
  output out_item_t      res_o
);

  logic [5:0]  phase_q, phase_d;
  logic        is_read_q, is_read_d;
  logic [15:0] send_q, send_d;
  logic [7:0]  recv_q, recv_d;
  pins_t       pins_q, pins_d;

  logic        is_start;
  logic [4:0]  j;
  logic [3:0]  bit_idx;
  logic [7:0]  wval;
  logic [7:0]  rshift;
  logic        done;
  logic        rej;
  logic [7:0]  rv;

  assign is_start = (item_i.opcode == OP_WRITE) || (item_i.opcode == OP_READ);
  assign j        = phase_q[4:0] - 5'd1;
  assign bit_idx  = j[4:1];
  assign wval     = bcd_i ? to_bcd(item_i.write_value) : item_i.write_value;
  assign rshift   = {1'b0, recv_q[7:1]};

  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    send_d    = send_q;
    recv_d    = recv_q;
    pins_d    = pins_q;
    done      = 1'b0;
    rej       = 1'b0;
    rv        = 8'd0;
    if (is_start) begin
      if (phase_q != PHASE_IDLE) begin
        rej = 1'b1;
      end else begin
        is_read_d = (item_i.opcode == OP_READ);
        send_d    = {(item_i.opcode == OP_WRITE) ? wval : 8'd0, item_i.command_byte};
        recv_d    = 8'd0;
        pins_d    = '{en: 1'b1, clk: 1'b0, dat: 1'b0, drv: 1'b1};
        phase_d   = PHASE_FIRST;
      end
    end else if (phase_q != PHASE_IDLE) begin
      if (phase_q >= PHASE_END) begin
        pins_d  = '0;
        phase_d = PHASE_IDLE;
        done    = 1'b1;
        if (is_read_q) begin
          rv = bcd_i ? from_bcd(rshift) : rshift;
        end
      end else begin
        if (is_read_q && (phase_q >= PHASE_READ)) begin
          if (!j[0]) begin
            pins_d = '{en: 1'b1, clk: 1'b1, dat: 1'b0, drv: 1'b0};
          end else begin
            pins_d = '{en: 1'b1, clk: 1'b0, dat: 1'b0, drv: 1'b0};
            recv_d = {item_i.data_pin_level, recv_q[7:1]};
          end
        end else if (!j[0]) begin
          pins_d = '{en: 1'b1, clk: 1'b0, dat: send_q[bit_idx], drv: 1'b1};
        end else begin
          pins_d.clk = 1'b1;
        end
        phase_d = phase_q + 6'd1;
      end
    end
  end

  always_comb begin
    res_o.enable_pin = pins_d.en;
    res_o.clock_pin  = pins_d.clk;
    res_o.data_out   = pins_d.dat & pins_d.drv;
    res_o.data_drive = pins_d.drv;
    res_o.busy_res   = (phase_d != PHASE_IDLE);
    res_o.done_res   = done;
    res_o.read_value = rv;
    res_o.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PHASE_IDLE;
      is_read_q <= 1'b0;
      send_q    <= '0;
      recv_q    <= '0;
      pins_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      send_q    <= send_d;
      recv_q    <= recv_d;
      pins_q    <= pins_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/three_wire_serial_register_master_unit.sv =====
// top level of the three-wire serial register master: input register,
// step core and result register; depends on tsrm_pkg and tsrm_core
// throughput: one item per cycle while the output is not stalled, set by the step in tsrm_core
// reset: asynchronous, active low; pins low, idle, bcd conversion off
`timescale 1ns / 1ps
`default_nettype none

module three_wire_serial_register_master_unit import tsrm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i
);

  logic      bcd_q;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t res;
  logic      out_free;
  logic      step;
  logic      in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_take    = !in_valid_q || out_free;
  assign in_stall_o = !in_take;

  tsrm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .bcd_i  (bcd_q),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= 1'b0;
    end else if (cfg_we_i) begin
      bcd_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result stage can move");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.done_res) |-> !out_item_o.busy_res)
    else $error("transaction end reported while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.rejected) |-> out_item_o.busy_res)
    else $error("command rejected while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.data_drive) |-> !out_item_o.data_out)
    else $error("data level shown on released line");

endmodule

`default_nettype wire
